@@ rtl/lsvm_pkg.sv @@
package lsvm_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [30:0] LABEL_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] INDEX_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] MANT_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [4:0]  FRAC_MAX  = 5'd31;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] K_LABEL   = 3'd0;
  localparam logic [2:0] K_PAIR    = 3'd1;
  localparam logic [2:0] K_BATCH   = 3'd2;
  localparam logic [2:0] K_DISCARD = 3'd3;
  localparam logic [2:0] K_ERROR   = 3'd4;

  typedef enum logic [3:0] {
    M_SKIP   = 4'd0,
    M_FIRST  = 4'd1,
    M_LINE   = 4'd2,
    M_LABEL  = 4'd3,
    M_VALUE  = 4'd4,
    M_GAP    = 4'd5,
    M_INDEX  = 4'd6,
    M_VSTART = 4'd7,
    M_DEAD   = 4'd8
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [30:0] row_label;
    logic [31:0] feature_index;
    logic [47:0] value_mantissa;
    logic [4:0]  value_fraction_digits;
    logic        last_result;
  } out_item_t;

  // up to two records produced by one byte, slot 0 first
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t r0;
    out_item_t r1;
  } res_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

@@ rtl/libsvm_text_record_parser.sv @@
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+-------------------------------
// input    | in_valid, in_stall, in_item             | one text byte or chunk end
// result   | out_valid, out_stall, out_item          | one record
// config   | cfg_valid, cfg_ready, cfg_rows_per_batch| rows_per_batch write
//
// One byte per cycle is taken while in_stall is low; the parse step runs on the input
// register, so a record passes through it and the result queue before it is on out_item.
// A byte may give two records; a 4-entry result queue absorbs this, and in_stall rises
// only while fewer than two entries are free.
// rst_n is synchronous: parser goes to skipping the first line, rows_per_batch to 1.
// cfg_ready is always high.
module libsvm_text_record_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsvm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lsvm_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_rows_per_batch
);

  logic                in_vld_r, in_vld_nxt;
  lsvm_pkg::in_item_t  in_r;
  logic [15:0]         rpb_r;
  logic                room;
  logic                fire;
  lsvm_pkg::res_push_t push;

  assign cfg_ready  = 1'b1;
  assign fire       = in_vld_r && room;
  assign in_stall   = in_vld_r && !room;
  assign in_vld_nxt = (in_valid && !in_stall) || (in_vld_r && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      rpb_r    <= 16'd1;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_valid && cfg_ready) rpb_r <= cfg_rows_per_batch;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_item;
  end

  lsvm_parse_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (in_r),
    .rows_per_batch (rpb_r),
    .push           (push)
  );

  lsvm_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ rtl/lsvm_parse_core.sv @@
module lsvm_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  lsvm_pkg::in_item_t  item,
  input  logic [15:0]         rows_per_batch,
  output lsvm_pkg::res_push_t push
);

  lsvm_pkg::parse_mode_t mode_r, mode_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic [30:0] lab_r, lab_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [47:0] man_r, man_nxt;
  logic [4:0]  frac_r, frac_nxt;
  logic [1:0]  dots_r, dots_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lsvm_pkg::M_SKIP;
      rows_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      rows_r <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lab_r  <= lab_nxt;
    idx_r  <= idx_nxt;
    man_r  <= man_nxt;
    frac_r <= frac_nxt;
    dots_r <= dots_nxt;
  end

  always_comb begin
    lsvm_pkg::parse_mode_t m;
    logic        endc;
    logic [7:0]  c;
    logic [7:0]  dsub;
    logic [3:0]  dig;
    logic        taken;
    logic        v0;
    logic        v1;
    logic [2:0]  k0;
    logic [2:0]  k1;
    logic [34:0] lab_t;
    logic [35:0] idx_t;
    logic [51:0] man_t;
    logic [15:0] rows_inc;

    mode_nxt = mode_r;
    rows_nxt = rows_r;
    lab_nxt  = lab_r;
    idx_nxt  = idx_r;
    man_nxt  = man_r;
    frac_nxt = frac_r;
    dots_nxt = dots_r;
    m        = mode_r;
    endc     = item.chunk_end;
    c        = endc ? lsvm_pkg::CH_NUL : item.text_byte;
    dsub     = c - lsvm_pkg::CH_ZERO;
    dig      = dsub[3:0];
    taken    = 1'b0;
    v0       = 1'b0;
    v1       = 1'b0;
    k0       = lsvm_pkg::K_LABEL;
    k1       = lsvm_pkg::K_LABEL;
    lab_t    = ({4'b0, lab_r} << 3) + ({4'b0, lab_r} << 1) + 35'(dig);
    idx_t    = ({4'b0, idx_r} << 3) + ({4'b0, idx_r} << 1) + 36'(dig);
    man_t    = ({4'b0, man_r} << 3) + ({4'b0, man_r} << 1) + 52'(dig);
    rows_inc = rows_r + 16'd1;

    if (fire) begin
      if (m == lsvm_pkg::M_SKIP) begin
        taken = 1'b1;
        if (endc) begin
          v0 = 1'b1; k0 = lsvm_pkg::K_ERROR;
        end else if (c == lsvm_pkg::CH_LF) begin
          m = lsvm_pkg::M_FIRST;
        end
      end else if (m == lsvm_pkg::M_FIRST) begin
        if (endc) begin
          v0 = 1'b1; k0 = lsvm_pkg::K_ERROR;
          taken = 1'b1;
          m = lsvm_pkg::M_DEAD;
        end else begin
          m = lsvm_pkg::M_LINE;
        end
      end else if (m > lsvm_pkg::M_DEAD) begin
        m = lsvm_pkg::M_DEAD;
      end

      if (!taken && m == lsvm_pkg::M_LINE) begin
        taken = 1'b1;
        if (lsvm_pkg::is_space(c)) begin
        end else if (lsvm_pkg::is_digit(c)) begin
          lab_nxt = 31'(dig);
          m = lsvm_pkg::M_LABEL;
        end else if (c == lsvm_pkg::CH_NUL) begin
          v0 = 1'b1; k0 = lsvm_pkg::K_DISCARD;
          m = lsvm_pkg::M_DEAD;
        end else begin
          v0 = 1'b1; k0 = lsvm_pkg::K_ERROR;
          m = lsvm_pkg::M_DEAD;
        end
      end

      if (!taken && m == lsvm_pkg::M_LABEL) begin
        if (lsvm_pkg::is_digit(c)) begin
          taken = 1'b1;
          lab_nxt = (lab_t > 35'(lsvm_pkg::LABEL_MAX)) ? lsvm_pkg::LABEL_MAX : lab_t[30:0];
        end else begin
          v0 = 1'b1; k0 = lsvm_pkg::K_LABEL;
          m = lsvm_pkg::M_GAP;
        end
      end

      if (!taken && m == lsvm_pkg::M_VALUE) begin
        if (lsvm_pkg::is_digit(c)) begin
          taken = 1'b1;
          if (dots_r == 2'd0) begin
            man_nxt = (man_t > 52'(lsvm_pkg::MANT_MAX)) ? lsvm_pkg::MANT_MAX : man_t[47:0];
          end else if (dots_r == 2'd1 && frac_r < lsvm_pkg::FRAC_MAX &&
                       man_t <= 52'(lsvm_pkg::MANT_MAX)) begin
            man_nxt  = man_t[47:0];
            frac_nxt = frac_r + 5'd1;
          end
        end else if (c == lsvm_pkg::CH_DOT) begin
          taken = 1'b1;
          if (dots_r != 2'd2) dots_nxt = dots_r + 2'd1;
        end else begin
          v0 = 1'b1; k0 = lsvm_pkg::K_PAIR;
          m = lsvm_pkg::M_GAP;
        end
      end

      // GAP may add a second record after a label or pair record
      if (!taken && m == lsvm_pkg::M_GAP) begin
        taken = 1'b1;
        if (c == lsvm_pkg::CH_LF) begin
          if (rows_inc >= rows_per_batch) begin
            if (v0) begin
              v1 = 1'b1; k1 = lsvm_pkg::K_BATCH;
            end else begin
              v0 = 1'b1; k0 = lsvm_pkg::K_BATCH;
            end
            rows_nxt = '0;
          end else begin
            rows_nxt = rows_inc;
          end
          m = lsvm_pkg::M_LINE;
        end else if (lsvm_pkg::is_space(c)) begin
        end else if (lsvm_pkg::is_digit(c)) begin
          idx_nxt = 32'(dig);
          m = lsvm_pkg::M_INDEX;
        end else begin
          if (v0) begin
            v1 = 1'b1;
            k1 = (c == lsvm_pkg::CH_NUL) ? lsvm_pkg::K_DISCARD : lsvm_pkg::K_ERROR;
          end else begin
            v0 = 1'b1;
            k0 = (c == lsvm_pkg::CH_NUL) ? lsvm_pkg::K_DISCARD : lsvm_pkg::K_ERROR;
          end
          m = lsvm_pkg::M_DEAD;
        end
      end

      if (!taken && m == lsvm_pkg::M_INDEX) begin
        taken = 1'b1;
        if (lsvm_pkg::is_digit(c)) begin
          idx_nxt = (idx_t > 36'(lsvm_pkg::INDEX_MAX)) ? lsvm_pkg::INDEX_MAX : idx_t[31:0];
        end else if (c == lsvm_pkg::CH_COLON) begin
          m = lsvm_pkg::M_VSTART;
        end else begin
          // missing colon ends the usable text quietly
          v0 = 1'b1; k0 = lsvm_pkg::K_DISCARD;
          m = lsvm_pkg::M_DEAD;
        end
      end

      if (!taken && m == lsvm_pkg::M_VSTART) begin
        if (lsvm_pkg::is_digit(c)) begin
          man_nxt  = 48'(dig);
          frac_nxt = '0;
          dots_nxt = '0;
          m = lsvm_pkg::M_VALUE;
        end else begin
          v0 = 1'b1; k0 = lsvm_pkg::K_ERROR;
          m = lsvm_pkg::M_DEAD;
        end
      end

      if (endc) begin
        m = lsvm_pkg::M_SKIP;
        rows_nxt = '0;
      end
      mode_nxt = m;
    end

    push.v0 = v0;
    push.v1 = v1;
    push.r0.record_kind           = k0;
    push.r0.row_label             = (k0 == lsvm_pkg::K_LABEL) ? lab_r : '0;
    push.r0.feature_index         = (k0 == lsvm_pkg::K_PAIR) ? idx_r : '0;
    push.r0.value_mantissa        = (k0 == lsvm_pkg::K_PAIR) ? man_r : '0;
    push.r0.value_fraction_digits = (k0 == lsvm_pkg::K_PAIR) ? frac_r : '0;
    push.r0.last_result           = !v1;
    // second slot only ever holds batch, discard or error
    push.r1.record_kind           = k1;
    push.r1.row_label             = '0;
    push.r1.feature_index         = '0;
    push.r1.value_mantissa        = '0;
    push.r1.value_fraction_digits = '0;
    push.r1.last_result           = 1'b1;
  end

endmodule

@@ rtl/lsvm_res_queue.sv @@
module lsvm_res_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  lsvm_pkg::res_push_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output lsvm_pkg::out_item_t out_item
);

  lsvm_pkg::out_item_t q_r [lsvm_pkg::QDEPTH];
  logic [lsvm_pkg::QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [lsvm_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_item  = q_r[rd_r];
  // space for a two-record transaction regardless of the pop
  assign room      = (cnt_r <= lsvm_pkg::QCNT_W'(lsvm_pkg::QDEPTH - 2));
  assign wr_p1     = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + lsvm_pkg::QPTR_W'(push.v0) + lsvm_pkg::QPTR_W'(push.v1);
    rd_nxt  = rd_r + lsvm_pkg::QPTR_W'(pop);
    cnt_nxt = cnt_r + lsvm_pkg::QCNT_W'(push.v0) + lsvm_pkg::QCNT_W'(push.v1)
              - lsvm_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) q_r[wr_r] <= push.r0;
    if (push.v1) q_r[wr_p1] <= push.r1;
  end

endmodule

@@ rtl/lsvm_checker.sv @@
module lsvm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lsvm_pkg::out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // batch, discard and error always close the transaction's records
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.record_kind == lsvm_pkg::K_BATCH ||
                  out_item.record_kind == lsvm_pkg::K_DISCARD ||
                  out_item.record_kind == lsvm_pkg::K_ERROR) |-> out_item.last_result)
    else $error("terminal record not marked last");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.record_kind <= lsvm_pkg::K_ERROR)
    else $error("bad record kind");

  a_label_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.record_kind != lsvm_pkg::K_LABEL |-> out_item.row_label == '0)
    else $error("label on non-label record");

  a_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.record_kind != lsvm_pkg::K_PAIR |->
      out_item.feature_index == '0 && out_item.value_mantissa == '0 &&
      out_item.value_fraction_digits == '0)
    else $error("pair fields on non-pair record");

endmodule

bind libsvm_text_record_parser lsvm_checker u_lsvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/lsvm_record_checker.sv @@
`timescale 1ns / 1ps

module lsvm_record_checker
  import lsvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_rows_per_batch,
  output int          fail_count,
  output int          pending
);

  out_item_t   expected_records[$];
  out_item_t   step_recs[2];
  int          step_count;

  logic [15:0] batch_rows;
  parse_mode_t mode;
  logic [15:0] rows_in_batch;
  logic [30:0] label_acc;
  logic [31:0] index_acc;
  logic [47:0] mant_acc;
  logic [4:0]  frac_cnt;
  logic [1:0]  dot_cnt;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic bit char_is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit char_is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_parser();
    mode          = M_SKIP;
    rows_in_batch = '0;
    label_acc     = '0;
    index_acc     = '0;
    mant_acc      = '0;
    frac_cnt      = '0;
    dot_cnt       = '0;
  endfunction

  function automatic void add_record(logic [2:0] kind, logic [30:0] lab, logic [31:0] idx,
                                     logic [47:0] mant, logic [4:0] frac);
    out_item_t r;
    r                       = '0;
    r.record_kind           = kind;
    r.row_label             = lab;
    r.feature_index         = idx;
    r.value_mantissa        = mant;
    r.value_fraction_digits = frac;
    if (step_count < 2) begin
      step_recs[step_count] = r;
      step_count++;
    end
  endfunction

  // One text byte or chunk end through the parser; queues the records it yields.
  function automatic void predict_records(in_item_t it);
    logic        fin;
    logic [7:0]  c;
    logic [63:0] dig;
    logic [63:0] t;
    bit          taken;
    fin        = it.chunk_end;
    c          = fin ? CH_NUL : it.text_byte;
    dig        = 64'(c - CH_ZERO);
    taken      = 1'b0;
    step_count = 0;

    if (mode == M_SKIP) begin
      taken = 1'b1;
      if (fin) add_record(K_ERROR, '0, '0, '0, '0);
      else if (c == CH_LF) mode = M_FIRST;
    end else if (mode == M_FIRST) begin
      if (fin) begin
        add_record(K_ERROR, '0, '0, '0, '0);
        taken = 1'b1;
        mode  = M_DEAD;
      end else begin
        mode = M_LINE;
      end
    end

    if (!taken && mode == M_LINE) begin
      taken = 1'b1;
      if (char_is_blank(c)) begin
      end else if (char_is_digit(c)) begin
        label_acc = 31'(dig);
        mode      = M_LABEL;
      end else if (c == CH_NUL) begin
        add_record(K_DISCARD, '0, '0, '0, '0);
        mode = M_DEAD;
      end else begin
        add_record(K_ERROR, '0, '0, '0, '0);
        mode = M_DEAD;
      end
    end

    if (!taken && mode == M_LABEL) begin
      if (char_is_digit(c)) begin
        taken     = 1'b1;
        t         = 64'(label_acc) * 64'd10 + dig;
        label_acc = (t > 64'(LABEL_MAX)) ? LABEL_MAX : t[30:0];
      end else begin
        add_record(K_LABEL, label_acc, '0, '0, '0);
        mode = M_GAP;
      end
    end

    if (!taken && mode == M_VALUE) begin
      if (char_is_digit(c)) begin
        taken = 1'b1;
        t     = 64'(mant_acc) * 64'd10 + dig;
        if (dot_cnt == 2'd0) begin
          mant_acc = (t > 64'(MANT_MAX)) ? MANT_MAX : t[47:0];
        end else if (dot_cnt == 2'd1 && frac_cnt < FRAC_MAX && t <= 64'(MANT_MAX)) begin
          // fractional digits that would overflow are truncated
          mant_acc = t[47:0];
          frac_cnt++;
        end
      end else if (c == CH_DOT) begin
        taken = 1'b1;
        if (dot_cnt < 2'd2) dot_cnt++;
      end else begin
        add_record(K_PAIR, '0, index_acc, mant_acc, frac_cnt);
        mode = M_GAP;
      end
    end

    if (!taken && mode == M_GAP) begin
      taken = 1'b1;
      if (c == CH_LF) begin
        rows_in_batch++;
        if (rows_in_batch >= batch_rows) begin
          add_record(K_BATCH, '0, '0, '0, '0);
          rows_in_batch = '0;
        end
        mode = M_LINE;
      end else if (char_is_blank(c)) begin
      end else if (char_is_digit(c)) begin
        index_acc = 32'(dig);
        mode      = M_INDEX;
      end else if (c == CH_NUL) begin
        add_record(K_DISCARD, '0, '0, '0, '0);
        mode = M_DEAD;
      end else begin
        add_record(K_ERROR, '0, '0, '0, '0);
        mode = M_DEAD;
      end
    end

    if (!taken && mode == M_INDEX) begin
      taken = 1'b1;
      if (char_is_digit(c)) begin
        t         = 64'(index_acc) * 64'd10 + dig;
        index_acc = (t > 64'(INDEX_MAX)) ? INDEX_MAX : t[31:0];
      end else if (c == CH_COLON) begin
        mode = M_VSTART;
      end else begin
        // missing colon ends the usable text quietly
        add_record(K_DISCARD, '0, '0, '0, '0);
        mode = M_DEAD;
      end
    end

    if (!taken && mode == M_VSTART) begin
      if (char_is_digit(c)) begin
        mant_acc = 48'(dig);
        frac_cnt = '0;
        dot_cnt  = '0;
        mode     = M_VALUE;
      end else begin
        add_record(K_ERROR, '0, '0, '0, '0);
        mode = M_DEAD;
      end
    end

    if (fin) clear_parser();
    if (step_count > 0) step_recs[step_count - 1].last_result = 1'b1;
    for (int i = 0; i < step_count; i++) begin
      expected_records.insert(expected_records.size(), step_recs[i]);
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_record(out_item_t got);
    out_item_t want;
    if (expected_records.size() == 0) begin
      $error("record_kind: expected none, got %0d", got.record_kind);
      fail_count++;
      return;
    end
    want = expected_records.pop_front();
    compare_field("record_kind", 64'(want.record_kind), 64'(got.record_kind));
    compare_field("row_label", 64'(want.row_label), 64'(got.row_label));
    compare_field("feature_index", 64'(want.feature_index), 64'(got.feature_index));
    compare_field("value_mantissa", 64'(want.value_mantissa), 64'(got.value_mantissa));
    compare_field("value_fraction_digits", 64'(want.value_fraction_digits),
                  64'(got.value_fraction_digits));
    compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
  endfunction

  // results pass through the input register and the result queue, so checking first is safe
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_records.delete();
      batch_rows = 16'd1;
      clear_parser();
    end else begin
      if (cfg_valid && cfg_ready) batch_rows = cfg_rows_per_batch;
      if (out_valid && !out_stall) check_record(out_item);
      if (in_valid && !in_stall) predict_records(in_item);
    end
    pending = expected_records.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lsvm_pkg::*;

  typedef enum int {ST_NONE, ST_LIGHT, ST_HEAVY, ST_BURST} stall_style_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  in_item_t    in_item            = '0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_rows_per_batch = 16'd1;
  int          fail_count;
  int          pending;

  int           burst_left  = 0;
  int           bytes_sent  = 0;
  stall_style_t stall_style = ST_NONE;
  int           stall_left  = 0;

  libsvm_text_record_parser dut (.*);
  lsvm_record_checker u_check (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_style)
      ST_NONE:  out_stall <= 1'b0;
      ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= (stall_left % 8) < 5;
    endcase
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // called and returns at a falling edge; valid stays up for a following transaction
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.text_byte = b;
    it.chunk_end = 1'b0;
    send_item(it);
  endtask

  task automatic end_chunk();
    in_item_t it;
    it.text_byte = 8'($urandom_range(0, 255));
    it.chunk_end = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_digits(int n);
    repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic send_junk(int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF) b = 8'h41;
      send_byte(b);
    end
  endtask

  task automatic send_blank();
    case ($urandom_range(0, 9))
      0:       send_byte(CH_TAB);
      1:       send_byte(8'($urandom_range(11, 13)));
      2:       begin send_byte(CH_SPACE); send_byte(CH_SPACE); end
      default: send_byte(CH_SPACE);
    endcase
  endtask

  // mostly short numbers, now and then long enough to saturate
  function automatic int pick_len(int longest);
    if ($urandom_range(0, 9) == 0) return $urandom_range(longest - 2, longest + 2);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_value();
    case ($urandom_range(0, 7))
      0: begin
        // all-zero fraction that can run into the fraction digit cap
        send_byte(CH_ZERO);
        send_byte(CH_DOT);
        repeat ($urandom_range(30, 34)) send_byte(CH_ZERO);
      end
      1: begin
        send_digits(pick_len(16));
        send_byte(CH_DOT);
        send_digits($urandom_range(0, 3));
        send_byte(CH_DOT);
        repeat ($urandom_range(0, 4)) send_byte($urandom_range(0, 3) == 0 ? CH_DOT : CH_NINE);
      end
      2: begin
        send_digits(pick_len(16));
        send_byte(CH_DOT);
      end
      default: begin
        send_digits(pick_len(16));
        if ($urandom_range(0, 1) == 0) begin
          send_byte(CH_DOT);
          send_digits(pick_len(16));
        end
      end
    endcase
  endtask

  task automatic random_row();
    if ($urandom_range(0, 9) == 0) send_blank();
    if ($urandom_range(0, 19) == 0) send_byte(CH_LF);
    send_digits(pick_len(11));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 39) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_blank();
      send_digits(pick_len(11));
      if ($urandom_range(0, 39) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(CH_COLON);
      send_value();
    end
    if ($urandom_range(0, 4) == 0) send_blank();
    send_byte(CH_LF);
  endtask

  task automatic random_chunk();
    send_junk($urandom_range(0, 4));
    if ($urandom_range(0, 19) == 0) begin
      end_chunk();
    end else begin
      send_byte(CH_LF);
      repeat ($urandom_range(0, 5)) random_row();
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          send_byte(CH_NUL);
          send_junk($urandom_range(0, 3));
        end
        2: begin
          // text cut short around the index
          send_digits(pick_len(11));
          send_blank();
          send_digits(pick_len(11));
          case ($urandom_range(0, 3))
            0: send_byte(CH_NUL);
            1: send_byte(CH_COLON);
            2: begin send_byte(8'h78); send_junk($urandom_range(0, 3)); end
            default: ;
          endcase
        end
        3: begin
          send_digits(pick_len(11));
          send_blank();
          send_digits(pick_len(11));
          send_byte(CH_COLON);
          send_value();
          if ($urandom_range(0, 1) == 0) send_byte(CH_NUL);
        end
        default: send_digits(pick_len(11));
      endcase
      end_chunk();
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_batch_rows(logic [15:0] rows);
    settle();
    cfg_valid          = 1'b1;
    cfg_rows_per_batch = rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [15:0] batch_plan[5];
    int          target;
    batch_plan = '{16'd65535, 16'd1, 16'd0, 16'd2, 16'd3};
    batch_plan[4] = 16'($urandom_range(3, 9));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // chunk end while skipping, right after the first newline, inside a value and after a bad index byte
    end_chunk();
    send_text("q\n");
    end_chunk();
    send_text("\n4 2:1.5\n7 9:8");
    end_chunk();
    send_text("\n3 5x");
    end_chunk();

    foreach (batch_plan[p]) begin
      set_batch_rows(batch_plan[p]);
      target = bytes_sent + 230;
      while (bytes_sent < target) random_chunk();
    end

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
